// ===== src/stf_pkg.sv =====
package stf_pkg;

  // Input item modes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_PIXEL = 2'd2;

  // Transition kinds
  localparam logic [3:0] KIND_FADE_BLACK = 4'd1;
  localparam logic [3:0] KIND_FADE_WHITE = 4'd2;
  localparam logic [3:0] KIND_WIPE_LEFT  = 4'd3;
  localparam logic [3:0] KIND_WIPE_RIGHT = 4'd4;
  localparam logic [3:0] KIND_WIPE_UP    = 4'd5;
  localparam logic [3:0] KIND_WIPE_DOWN  = 4'd6;
  localparam logic [3:0] KIND_RADIAL     = 4'd7;

  // Configuration register indexes
  localparam logic [1:0] REG_KIND    = 2'd0;
  localparam logic [1:0] REG_REVERSE = 2'd1;
  localparam logic [1:0] REG_STEP    = 2'd2;
  localparam logic [1:0] REG_COLOUR  = 2'd3;

  localparam logic [7:0] STEP_RESET = 8'd8;
  localparam logic [7:0] PROG_FULL  = 8'd255;

  // Depth of the queue between front and back
  localparam int QDEPTH = 2;

  // Work the back end does for one item
  typedef enum logic [2:0] {
    OP_ZERO,
    OP_PASS,
    OP_FADE,
    OP_WIPE_L,
    OP_WIPE_R,
    OP_WIPE_U,
    OP_WIPE_D,
    OP_RADIAL
  } stf_op_t;

  // Classified item handed from front to back
  typedef struct packed {
    stf_op_t     op;
    logic [8:0]  x;
    logic [7:0]  y;
    logic [15:0] bg;
    logic [7:0]  e;
    logic        running;
    logic        finished;
    logic        pulse;
  } stf_item_t;

  // Floor square root, elaboration use only
  function automatic int unsigned isqrt(input int unsigned v);
    int unsigned rem;
    int unsigned root;
    int unsigned bitv;
    rem  = v;
    root = 0;
    bitv = 32'h4000_0000;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Floor of v / 255: series estimate, then one correction step
  function automatic logic [23:0] div255(input logic [23:0] v);
    logic [25:0] acc;
    logic [23:0] q;
    logic [31:0] rem;
    acc = 26'(v) + 26'(v >> 8) + 26'(v >> 16);
    q   = 24'(acc >> 8);
    rem = 32'(v) - ((32'(q) << 8) - 32'(q));
    if (rem >= 32'd255) q = q + 24'd1;
    return q;
  endfunction

endpackage

// ===== src/stf_front.sv =====
module stf_front #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [8:0]         in_pixel_x,
  input  logic [7:0]         in_pixel_y,
  input  logic [15:0]        in_background_pixel,
  input  logic               q_full,
  output logic               q_push,
  output stf_pkg::stf_item_t q_item,
  output logic [15:0]        colour
);
  import stf_pkg::*;

  localparam int WW  = $clog2(SCREEN_WIDTH + 1);
  localparam int HW  = $clog2(SCREEN_HEIGHT + 1);
  localparam int XCW = (WW > 9) ? WW : 9;
  localparam int YCW = (HW > 8) ? HW : 8;

  logic [3:0]  kind_r;
  logic        reverse_r;
  logic [7:0]  step_r;
  logic [15:0] colour_r;

  logic [7:0]  progress_r, progress_nxt;
  logic        active_r, active_nxt;
  logic        complete_r, complete_nxt;
  logic        pulse;
  logic [8:0]  sum;
  logic        offscreen;
  stf_op_t     pix_op;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign colour   = colour_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r    <= '0;
      reverse_r <= 1'b0;
      step_r    <= STEP_RESET;
      colour_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KIND:    kind_r    <= cfg_data[3:0];
        REG_REVERSE: reverse_r <= cfg_data[0];
        REG_STEP:    step_r    <= cfg_data[7:0];
        REG_COLOUR:  colour_r  <= cfg_data;
        default:     ;
      endcase
    end
  end

  // Transition state update
  always_comb begin
    progress_nxt = progress_r;
    active_nxt   = active_r;
    complete_nxt = complete_r;
    pulse        = 1'b0;
    sum          = 9'(progress_r) + 9'(step_r);
    unique case (in_mode)
      MODE_START: begin
        progress_nxt = '0;
        active_nxt   = 1'b1;
        complete_nxt = 1'b0;
      end
      MODE_TICK: begin
        if (active_r && !complete_r) begin
          if (sum >= 9'(PROG_FULL)) begin
            progress_nxt = PROG_FULL;
            complete_nxt = 1'b1;
            active_nxt   = 1'b0;
            pulse        = 1'b1;
          end else begin
            progress_nxt = sum[7:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      progress_r <= '0;
      active_r   <= 1'b0;
      complete_r <= 1'b0;
    end else if (q_push) begin
      progress_r <= progress_nxt;
      active_r   <= active_nxt;
      complete_r <= complete_nxt;
    end
  end

  // Pixel classification
  assign offscreen = (XCW'(in_pixel_x) >= XCW'(SCREEN_WIDTH)) ||
                     (YCW'(in_pixel_y) >= YCW'(SCREEN_HEIGHT));

  always_comb begin
    pix_op = OP_PASS;
    if ((active_r || complete_r) && !offscreen) begin
      unique case (kind_r)
        KIND_FADE_BLACK, KIND_FADE_WHITE: pix_op = OP_FADE;
        KIND_WIPE_LEFT:  pix_op = OP_WIPE_L;
        KIND_WIPE_RIGHT: pix_op = OP_WIPE_R;
        KIND_WIPE_UP:    pix_op = OP_WIPE_U;
        KIND_WIPE_DOWN:  pix_op = OP_WIPE_D;
        KIND_RADIAL:     pix_op = OP_RADIAL;
        default:         pix_op = OP_PASS;
      endcase
    end
  end

  always_comb begin
    q_item.op       = (in_mode == MODE_PIXEL) ? pix_op : OP_ZERO;
    q_item.x        = in_pixel_x;
    q_item.y        = in_pixel_y;
    q_item.bg       = in_background_pixel;
    q_item.e        = reverse_r ? (PROG_FULL - progress_r) : progress_r;
    q_item.running  = active_nxt;
    q_item.finished = complete_nxt;
    q_item.pulse    = pulse;
  end

`ifndef NO_ASSERTIONS
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(active_r && complete_r))
    else $error("active and complete set together");

  a_complete_full: assert property (@(posedge clk) disable iff (!rst_n)
    complete_r |-> (progress_r == PROG_FULL))
    else $error("complete without full progress");
`endif

endmodule

// ===== src/stf_queue.sv =====
module stf_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  stf_pkg::stf_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output stf_pkg::stf_item_t head
);
  import stf_pkg::*;

  localparam int QPW = $clog2(QDEPTH);

  stf_item_t        mem_r [QDEPTH];
  logic [QPW-1:0]   wr_ptr_r;
  logic [QPW-1:0]   rd_ptr_r;
  logic [QPW:0]     count_r;

  assign full  = (count_r == (QPW + 1)'(QDEPTH));
  assign valid = (count_r != '0);
  assign head  = mem_r[rd_ptr_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QPW + 1)'(QDEPTH))
    else $error("queue count beyond depth");

  a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("pop from empty queue");
`endif

endmodule

// ===== src/stf_back.sv =====
module stf_back #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  stf_pkg::stf_item_t q_item,
  output logic               q_pop,
  input  logic [15:0]        colour,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_pixel_result,
  output logic               out_running,
  output logic               out_finished,
  output logic               out_finished_now
);
  import stf_pkg::*;

  localparam int WW   = $clog2(SCREEN_WIDTH + 1);
  localparam int HW   = $clog2(SCREEN_HEIGHT + 1);
  localparam int XWL  = (WW > 10) ? WW : 10;
  localparam int YWL  = (HW > 9) ? HW : 9;
  localparam int PXW  = XWL + 8;
  localparam int PYW  = YWL + 8;
  localparam int CX   = SCREEN_WIDTH / 2;
  localparam int CY   = SCREEN_HEIGHT / 2;
  localparam int RMAX = int'(isqrt(CX * CX + CY * CY));
  localparam int RW   = $clog2(RMAX + 1);
  localparam int MW   = (XWL > YWL) ? XWL : YWL;
  localparam int D2W  = 2 * MW + 1;
  localparam int RSW  = 2 * RW + 2;
  localparam int CMPW = (D2W > RSW) ? D2W : RSW;

  logic en;

  // Stage 1: products and distances
  logic        s1_valid_r;
  stf_op_t     s1_op_r;
  logic [15:0] s1_bg_r;
  logic [2:0]  s1_flags_r;
  logic [13:0] s1_fr_r, s1_fg_r, s1_fb_r;
  logic [PXW-1:0] s1_ew_r, s1_lx_r, s1_rx_r;
  logic [PYW-1:0] s1_eh_r, s1_uy_r, s1_dy_r;
  logic [RW+7:0]  s1_er_r;
  logic [XWL-1:0] s1_adx_r;
  logic [YWL-1:0] s1_ady_r;

  // Stage 2: fade result, wipe decision, squares, radius
  logic        s2_valid_r;
  stf_op_t     s2_op_r;
  logic [15:0] s2_bg_r;
  logic [2:0]  s2_flags_r;
  logic [15:0] s2_fade_r;
  logic        s2_wcover_r;
  logic [2*XWL-1:0] s2_dx2_r;
  logic [2*YWL-1:0] s2_dy2_r;
  logic [RW-1:0]    s2_r_r;

  // Stage 3: squared distance and squared radius
  logic        s3_valid_r;
  stf_op_t     s3_op_r;
  logic [15:0] s3_bg_r;
  logic [2:0]  s3_flags_r;
  logic [15:0] s3_fade_r;
  logic        s3_wcover_r;
  logic [CMPW-1:0] s3_d2_r;
  logic [CMPW-1:0] s3_rsq_r;

  // Output register
  logic        out_valid_r;
  logic [15:0] out_pix_r;
  logic [2:0]  out_flags_r;

  logic [7:0]     ie;
  logic [XWL-1:0] xe;
  logic [YWL-1:0] ye;
  logic [RW:0]    rp1;
  logic           wcover;
  logic [15:0]    result;

  assign en    = !out_valid_r || out_ready;
  assign q_pop = q_valid && en;

  assign ie = PROG_FULL - q_item.e;
  assign xe = XWL'(q_item.x);
  assign ye = YWL'(q_item.y);

  // Valid bits shift together while the output can move
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= q_valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  // Stage 1
  always_ff @(posedge clk) begin
    if (en) begin
      s1_op_r    <= q_item.op;
      s1_bg_r    <= q_item.bg;
      s1_flags_r <= {q_item.running, q_item.finished, q_item.pulse};
      s1_fr_r    <= 14'(colour[15:11]) * 14'(q_item.e) + 14'(q_item.bg[15:11]) * 14'(ie);
      s1_fg_r    <= 14'(colour[10:5]) * 14'(q_item.e) + 14'(q_item.bg[10:5]) * 14'(ie);
      s1_fb_r    <= 14'(colour[4:0]) * 14'(q_item.e) + 14'(q_item.bg[4:0]) * 14'(ie);
      s1_ew_r    <= PXW'(q_item.e) * PXW'(SCREEN_WIDTH);
      s1_lx_r    <= PXW'(8'd255) * (PXW'(xe) + PXW'(1));
      s1_rx_r    <= PXW'(8'd255) * (PXW'(SCREEN_WIDTH) - PXW'(xe));
      s1_eh_r    <= PYW'(q_item.e) * PYW'(SCREEN_HEIGHT);
      s1_uy_r    <= PYW'(8'd255) * (PYW'(ye) + PYW'(1));
      s1_dy_r    <= PYW'(8'd255) * (PYW'(SCREEN_HEIGHT) - PYW'(ye));
      s1_er_r    <= (RW + 8)'(q_item.e) * (RW + 8)'(RMAX);
      s1_adx_r   <= (xe >= XWL'(CX)) ? (xe - XWL'(CX)) : (XWL'(CX) - xe);
      s1_ady_r   <= (ye >= YWL'(CY)) ? (ye - YWL'(CY)) : (YWL'(CY) - ye);
    end
  end

  // Wipe edge compare, scaled by 255 on both sides
  always_comb begin
    unique case (s1_op_r)
      OP_WIPE_L: wcover = (s1_lx_r <= s1_ew_r);
      OP_WIPE_R: wcover = (s1_ew_r >= s1_rx_r);
      OP_WIPE_U: wcover = (s1_uy_r <= s1_eh_r);
      OP_WIPE_D: wcover = (s1_eh_r >= s1_dy_r);
      default:   wcover = 1'b0;
    endcase
  end

  // Stage 2
  always_ff @(posedge clk) begin
    if (en) begin
      s2_op_r     <= s1_op_r;
      s2_bg_r     <= s1_bg_r;
      s2_flags_r  <= s1_flags_r;
      s2_fade_r   <= {5'(div255(24'(s1_fr_r))), 6'(div255(24'(s1_fg_r))),
                      5'(div255(24'(s1_fb_r)))};
      s2_wcover_r <= wcover;
      s2_dx2_r    <= (2 * XWL)'(s1_adx_r) * (2 * XWL)'(s1_adx_r);
      s2_dy2_r    <= (2 * YWL)'(s1_ady_r) * (2 * YWL)'(s1_ady_r);
      s2_r_r      <= RW'(div255(24'(s1_er_r)));
    end
  end

  assign rp1 = (RW + 1)'(s2_r_r) + (RW + 1)'(1);

  // Stage 3
  always_ff @(posedge clk) begin
    if (en) begin
      s3_op_r     <= s2_op_r;
      s3_bg_r     <= s2_bg_r;
      s3_flags_r  <= s2_flags_r;
      s3_fade_r   <= s2_fade_r;
      s3_wcover_r <= s2_wcover_r;
      s3_d2_r     <= CMPW'(s2_dx2_r) + CMPW'(s2_dy2_r);
      s3_rsq_r    <= CMPW'(rp1) * CMPW'(rp1);
    end
  end

  // Final selection
  always_comb begin
    unique case (s3_op_r)
      OP_ZERO:   result = '0;
      OP_PASS:   result = s3_bg_r;
      OP_FADE:   result = s3_fade_r;
      OP_RADIAL: result = (s3_d2_r >= s3_rsq_r) ? colour : s3_bg_r;
      default:   result = s3_wcover_r ? colour : s3_bg_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pix_r   <= result;
      out_flags_r <= s3_flags_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_result = out_pix_r;
  assign out_running      = out_flags_r[2];
  assign out_finished     = out_flags_r[1];
  assign out_finished_now = out_flags_r[0];

`ifndef NO_ASSERTIONS
  a_pulse_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_finished_now) |-> (out_finished && !out_running))
    else $error("completion pulse without finished state");
`endif

endmodule

// ===== src/screen_transition_overlay_top.sv =====
// Channel  | Direction | Handshake          | Payload
// in_      | input     | in_valid/in_ready  | mode, pixel_x, pixel_y, background_pixel
// out_     | output    | out_valid/out_ready| pixel_result, running, finished, finished_now
// cfg_     | input     | cfg_we             | cfg_index, cfg_data
//
// One item per clock sustained while the output is not stalled; each item passes the
// queue slot, three arithmetic stages and the output register on its way to out_valid.
// Start and tick items update state as they are taken, pixels carry a copy of progress.
// rst_n is synchronous: registers to reset values, state cleared, queue and pipe empty.
// A stalled output holds the pipe; the two-entry queue fills up, and then
// in_ready drops until the output moves again.
module screen_transition_overlay_top #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [8:0]  in_pixel_x,
  input  logic [7:0]  in_pixel_y,
  input  logic [15:0] in_background_pixel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_pixel_result,
  output logic        out_running,
  output logic        out_finished,
  output logic        out_finished_now
);
  import stf_pkg::*;

  logic        q_full;
  logic        q_push;
  logic        q_pop;
  logic        q_valid;
  stf_item_t   push_item;
  stf_item_t   head_item;
  logic [15:0] colour;

  // Front: configuration, state, classification
  stf_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_pixel_x         (in_pixel_x),
    .in_pixel_y         (in_pixel_y),
    .in_background_pixel(in_background_pixel),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_item             (push_item),
    .colour             (colour)
  );

  // Queue between front and back
  stf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_item(push_item),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (head_item)
  );

  // Back: pixel arithmetic and output register
  stf_back #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (head_item),
    .q_pop           (q_pop),
    .colour          (colour),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_result(out_pixel_result),
    .out_running     (out_running),
    .out_finished    (out_finished),
    .out_finished_now(out_finished_now)
  );

endmodule

// ===== bench/tb_screen_transition_overlay_top.sv =====
module tb_screen_transition_overlay_top;
  timeunit 1ns;
  timeprecision 1ps;

  import stf_pkg::*;

  localparam int SCREEN_W      = 320;
  localparam int SCREEN_H      = 240;
  localparam int PIPE_LATENCY  = 4;
  localparam int RANDOM_ITEMS  = 720;
  localparam int STALL_LIMIT   = 2000;

  // codes with no name in the package
  localparam logic [1:0] MODE_UNUSED   = 2'd3;
  localparam logic [3:0] KIND_NONE     = 4'd0;
  localparam logic [3:0] KIND_GLITCH   = 4'd8;
  localparam logic [3:0] KIND_PIXELATE = 4'd9;

  typedef struct packed {
    logic [15:0] pix;
    logic        run;
    logic        fin;
    logic        now;
  } px_result_t;

  typedef enum logic {ROW_ITEM, ROW_SETTINGS} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  mode;
    logic [8:0]  x;
    logic [7:0]  y;
    logic [15:0] bg;
    bit          known;
    px_result_t  want;
    logic [15:0] set_kind;
    logic [15:0] set_rev;
    logic [15:0] set_step;
    logic [15:0] set_colour;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_KIND;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = MODE_START;
  logic [8:0]  in_pixel_x = '0;
  logic [7:0]  in_pixel_y = '0;
  logic [15:0] in_background_pixel = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_pixel_result;
  logic        out_running;
  logic        out_finished;
  logic        out_finished_now;

  screen_transition_overlay_top #(
    .SCREEN_WIDTH  (SCREEN_W),
    .SCREEN_HEIGHT (SCREEN_H)
  ) uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_mode             (in_mode),
    .in_pixel_x          (in_pixel_x),
    .in_pixel_y          (in_pixel_y),
    .in_background_pixel (in_background_pixel),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_pixel_result    (out_pixel_result),
    .out_running         (out_running),
    .out_finished        (out_finished),
    .out_finished_now    (out_finished_now)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // transition state as the bench sees it
  logic [3:0]  cur_kind = KIND_NONE;
  logic        cur_rev = 1'b0;
  logic [7:0]  cur_step = STEP_RESET;
  logic [15:0] cur_colour = '0;
  logic [7:0]  prog = '0;
  logic        active = 1'b0;
  logic        done = 1'b0;
  int unsigned full_radius;

  px_result_t  expected_px[$];
  step_row_t   opening_rows[$];

  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned completions = 0;
  int unsigned pixels_sent = 0;
  int unsigned ticks_sent = 0;
  int unsigned starts_sent = 0;
  int unsigned random_items = 0;
  int unsigned setting_loads = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;

  function automatic int unsigned blend(int unsigned fg, int unsigned bg, int unsigned a);
    return (fg * a + bg * (255 - a)) / 255;
  endfunction

  // pixel after the overlay, from the current state and settings
  function automatic logic [15:0] overlay_of(logic [8:0] x, logic [7:0] y, logic [15:0] bg);
    int unsigned e;
    int unsigned p;
    int unsigned rr;
    int          dx;
    int          dy;
    logic [4:0]  rch;
    logic [5:0]  gch;
    logic [4:0]  bch;
    if (!active && !done) return bg;
    if (x >= SCREEN_W || y >= SCREEN_H) return bg;
    e = cur_rev ? 255 - prog : prog;
    case (cur_kind)
      KIND_FADE_BLACK, KIND_FADE_WHITE: begin
        rch = 5'(blend(cur_colour[15:11], bg[15:11], e));
        gch = 6'(blend(cur_colour[10:5], bg[10:5], e));
        bch = 5'(blend(cur_colour[4:0], bg[4:0], e));
        return {rch, gch, bch};
      end
      KIND_WIPE_LEFT: begin
        p = e * SCREEN_W / 255;
        return (x < p) ? cur_colour : bg;
      end
      KIND_WIPE_RIGHT: begin
        p = e * SCREEN_W / 255;
        return (x >= SCREEN_W - p) ? cur_colour : bg;
      end
      KIND_WIPE_UP: begin
        p = e * SCREEN_H / 255;
        return (y < p) ? cur_colour : bg;
      end
      KIND_WIPE_DOWN: begin
        p = e * SCREEN_H / 255;
        return (y >= SCREEN_H - p) ? cur_colour : bg;
      end
      KIND_RADIAL: begin
        rr = e * full_radius / 255;
        dx = int'(x) - SCREEN_W / 2;
        dy = int'(y) - SCREEN_H / 2;
        return (int'(dx * dx + dy * dy) >= int'((rr + 1) * (rr + 1))) ? cur_colour : bg;
      end
      default: return bg;
    endcase
  endfunction

  // advances the transition state by one item and returns its result
  function automatic px_result_t predict_result(logic [1:0] mode, logic [8:0] x,
                                                logic [7:0] y, logic [15:0] bg);
    px_result_t  r;
    int unsigned sum;
    r = '0;
    case (mode)
      MODE_START: begin
        prog   = '0;
        active = 1'b1;
        done   = 1'b0;
      end
      MODE_TICK: begin
        if (active && !done) begin
          sum = prog + cur_step;
          if (sum >= 255) begin
            prog   = PROG_FULL;
            done   = 1'b1;
            active = 1'b0;
            r.now  = 1'b1;
          end else begin
            prog = 8'(sum);
          end
        end
      end
      MODE_PIXEL: r.pix = overlay_of(x, y, bg);
      default: ;
    endcase
    r.run = active;
    r.fin = done;
    return r;
  endfunction

  function automatic step_row_t item_row(logic [1:0] mode, logic [8:0] x, logic [7:0] y,
                                         logic [15:0] bg);
    step_row_t r;
    r = '{kind: ROW_ITEM, mode: mode, x: x, y: y, bg: bg, known: 1'b0, want: '0,
          default: '0};
    return r;
  endfunction

  function automatic step_row_t known_row(logic [1:0] mode, logic [8:0] x, logic [7:0] y,
                                          logic [15:0] bg, logic [15:0] pix, logic run,
                                          logic fin, logic now);
    step_row_t r;
    r = item_row(mode, x, y, bg);
    r.known = 1'b1;
    r.want  = '{pix: pix, run: run, fin: fin, now: now};
    return r;
  endfunction

  function automatic step_row_t settings_row(logic [3:0] kind, logic rev, logic [7:0] step,
                                             logic [15:0] colour);
    step_row_t r;
    r = '{kind: ROW_SETTINGS, set_kind: 16'(kind), set_rev: 16'(rev),
          set_step: 16'(step), set_colour: colour, default: '0};
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
    errors++;
  endtask

  // one item out, in bursts with random gaps
  task automatic send_item(logic [1:0] mode, logic [8:0] x, logic [7:0] y, logic [15:0] bg,
                           bit known, px_result_t want);
    px_result_t predicted;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 30);
    end
    predicted = predict_result(mode, x, y, bg);
    expected_px.push_back(known ? want : predicted);
    case (mode)
      MODE_START: starts_sent++;
      MODE_TICK:  ticks_sent++;
      MODE_PIXEL: pixels_sent++;
      default: ;
    endcase
    in_valid            <= 1'b1;
    in_mode             <= mode;
    in_pixel_x          <= x;
    in_pixel_y          <= y;
    in_background_pixel <= bg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  // let every expected item come out before touching registers
  task automatic settle_pipe();
    in_valid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  task automatic load_settings(logic [15:0] kind_word, logic [15:0] rev_word,
                               logic [15:0] step_word, logic [15:0] colour_word);
    cfg_we    <= 1'b1;
    cfg_index <= REG_KIND;
    cfg_data  <= kind_word;
    @(posedge clk);
    cfg_index <= REG_REVERSE;
    cfg_data  <= rev_word;
    @(posedge clk);
    cfg_index <= REG_STEP;
    cfg_data  <= step_word;
    @(posedge clk);
    cfg_index <= REG_COLOUR;
    cfg_data  <= colour_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_kind   = kind_word[3:0];
    cur_rev    = rev_word[0];
    cur_step   = step_word[7:0];
    cur_colour = colour_word;
    setting_loads++;
  endtask

  // receiver: switches between random stall styles
  int unsigned rx_tick = 0;
  int unsigned rx_style = 0;
  always @(posedge clk) begin
    rx_tick++;
    if (rx_tick % 128 == 0) rx_style = $urandom_range(0, 3);
    case (rx_style)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ((rx_tick % 9) >= 4);
    endcase
  end

  // result checker
  always @(posedge clk) begin
    px_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_finished_now) completions++;
      if (expected_px.size() == 0) begin
        report_mismatch("item with nothing expected, pixel", out_pixel_result, 0);
      end else begin
        want = expected_px.pop_front();
        if (out_pixel_result !== want.pix)
          report_mismatch("pixel_result", out_pixel_result, want.pix);
        if (out_running !== want.run) report_mismatch("running", out_running, want.run);
        if (out_finished !== want.fin) report_mismatch("finished", out_finished, want.fin);
        if (out_finished_now !== want.now)
          report_mismatch("finished_now", out_finished_now, want.now);
      end
    end
  end

  // watchdog on cycles with no traffic at all
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no traffic for %0d cycles, %0d items outstanding",
               idle_cycles, expected_px.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    step_row_t   row;
    logic [1:0]  mode;
    logic [8:0]  x;
    logic [7:0]  y;
    logic [3:0]  kind;
    logic [7:0]  step;
    logic [15:0] colour;
    int unsigned pick;
    int unsigned phase_len;

    // floor root of the corner distance squared
    full_radius = 0;
    while ((full_radius + 1) * (full_radius + 1) <=
           (SCREEN_W / 2) * (SCREEN_W / 2) + (SCREEN_H / 2) * (SCREEN_H / 2))
      full_radius++;

    // idle block: pass-through, quiet tick, unused mode
    opening_rows.push_back(known_row(MODE_PIXEL, 9'd0, 8'd0, 16'hFFFF, 16'hFFFF, 0, 0, 0));
    opening_rows.push_back(known_row(MODE_TICK, 9'd0, 8'd0, 16'h0000, 16'h0000, 0, 0, 0));
    opening_rows.push_back(known_row(MODE_UNUSED, 9'd319, 8'd239, 16'hABCD, 16'h0000, 0, 0, 0));
    // full step fade: one tick completes, then stays done
    opening_rows.push_back(settings_row(KIND_FADE_BLACK, 1'b0, 8'd255, 16'hFFFF));
    opening_rows.push_back(known_row(MODE_START, 9'd0, 8'd0, 16'h0000, 16'h0000, 1, 0, 0));
    opening_rows.push_back(item_row(MODE_PIXEL, 9'd319, 8'd239, 16'h0000));
    opening_rows.push_back(known_row(MODE_TICK, 9'd0, 8'd0, 16'h0000, 16'h0000, 0, 1, 1));
    opening_rows.push_back(known_row(MODE_TICK, 9'd0, 8'd0, 16'h0000, 16'h0000, 0, 1, 0));
    opening_rows.push_back(known_row(MODE_PIXEL, 9'd100, 8'd50, 16'h1234, 16'hFFFF, 0, 1, 0));
    opening_rows.push_back(known_row(MODE_PIXEL, 9'd320, 8'd0, 16'h1234, 16'h1234, 0, 1, 0));
    opening_rows.push_back(known_row(MODE_PIXEL, 9'd511, 8'd255, 16'h5A5A, 16'h5A5A, 0, 1, 0));
    // zero step, reversed fade
    opening_rows.push_back(settings_row(KIND_FADE_WHITE, 1'b1, 8'd0, 16'h07E0));
    opening_rows.push_back(known_row(MODE_START, 9'd0, 8'd0, 16'h0000, 16'h0000, 1, 0, 0));
    opening_rows.push_back(known_row(MODE_TICK, 9'd0, 8'd0, 16'h0000, 16'h0000, 1, 0, 0));
    opening_rows.push_back(item_row(MODE_PIXEL, 9'd160, 8'd120, 16'hF81F));
    // wipes from both sides, second one saturating
    opening_rows.push_back(settings_row(KIND_WIPE_LEFT, 1'b1, 8'd200, 16'hF800));
    opening_rows.push_back(item_row(MODE_START, 9'd0, 8'd0, 16'h0000));
    opening_rows.push_back(item_row(MODE_TICK, 9'd0, 8'd0, 16'h0000));
    opening_rows.push_back(item_row(MODE_PIXEL, 9'd0, 8'd0, 16'h0000));
    opening_rows.push_back(settings_row(KIND_WIPE_RIGHT, 1'b0, 8'd200, 16'h001F));
    opening_rows.push_back(item_row(MODE_START, 9'd0, 8'd0, 16'h0000));
    opening_rows.push_back(item_row(MODE_TICK, 9'd0, 8'd0, 16'h0000));
    opening_rows.push_back(item_row(MODE_PIXEL, 9'd319, 8'd10, 16'h0000));
    opening_rows.push_back(known_row(MODE_TICK, 9'd0, 8'd0, 16'h0000, 16'h0000, 0, 1, 1));
    // radial, centre and corner
    opening_rows.push_back(settings_row(KIND_RADIAL, 1'b0, 8'd128, 16'hFFE0));
    opening_rows.push_back(item_row(MODE_START, 9'd0, 8'd0, 16'h0000));
    opening_rows.push_back(item_row(MODE_TICK, 9'd0, 8'd0, 16'h0000));
    opening_rows.push_back(item_row(MODE_PIXEL, 9'd160, 8'd120, 16'h0000));
    opening_rows.push_back(item_row(MODE_PIXEL, 9'd0, 8'd0, 16'h0000));
    // a kind with no overlay
    opening_rows.push_back(settings_row(KIND_PIXELATE, 1'b0, 8'd8, 16'hFFFF));
    opening_rows.push_back(item_row(MODE_START, 9'd0, 8'd0, 16'h0000));
    opening_rows.push_back(item_row(MODE_PIXEL, 9'd5, 8'd5, 16'h1357));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening_rows[i]) begin
      row = opening_rows[i];
      if (row.kind == ROW_SETTINGS) begin
        settle_pipe();
        load_settings(row.set_kind, row.set_rev, row.set_step, row.set_colour);
      end else begin
        send_item(row.mode, row.x, row.y, row.bg, row.known, row.want);
      end
    end

    // random phases: fresh settings, then mostly start/tick/pixel sequences
    while (random_items < RANDOM_ITEMS) begin
      settle_pipe();
      pick = $urandom_range(0, 19);
      if (pick < 14)       kind = 4'($urandom_range(KIND_FADE_BLACK, KIND_RADIAL));
      else if (pick == 14) kind = KIND_NONE;
      else if (pick == 15) kind = KIND_GLITCH;
      else if (pick == 16) kind = KIND_PIXELATE;
      else                 kind = 4'($urandom_range(10, 15));
      case ($urandom_range(0, 5))
        0: step = 8'd0;
        1: step = 8'd255;
        2: step = 8'd1;
        default: step = 8'($urandom_range(2, 60));
      endcase
      case ($urandom_range(0, 3))
        0: colour = 16'h0000;
        1: colour = 16'hFFFF;
        default: colour = 16'($urandom);
      endcase
      load_settings((16'($urandom) & 16'hFFF0) | 16'(kind), 16'($urandom),
                    (16'($urandom) & 16'hFF00) | 16'(step), colour);

      phase_len = $urandom_range(20, 80);
      for (int n = 0; n < phase_len; n++) begin
        x = 9'($urandom);
        y = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (n == 0 && $urandom_range(0, 9) != 0) mode = MODE_START;
        else if (pick < 60) mode = MODE_PIXEL;
        else if (pick < 86) mode = MODE_TICK;
        else if (pick < 92) mode = MODE_UNUSED;
        else if (pick < 95) mode = MODE_START;
        else mode = MODE_PIXEL;
        // most pixels on screen, a few at corners, the rest anywhere
        if (mode == MODE_PIXEL) begin
          case ($urandom_range(0, 9))
            0: ;
            1: begin
              x = ($urandom_range(0, 1) == 1) ? 9'(SCREEN_W - 1) : 9'd0;
              y = ($urandom_range(0, 1) == 1) ? 8'(SCREEN_H - 1) : 8'd0;
            end
            default: begin
              x = 9'($urandom_range(0, SCREEN_W - 1));
              y = 8'($urandom_range(0, SCREEN_H - 1));
            end
          endcase
        end
        send_item(mode, x, y, 16'($urandom), 1'b0, '0);
        random_items++;
      end
    end

    settle_pipe();
    repeat (PIPE_LATENCY) @(posedge clk);

    $display("run covered %0d results over %0d register settings: %0d pixels, %0d ticks, %0d starts",
             results_seen, setting_loads, pixels_sent, ticks_sent, starts_sent);
    $display("transitions completed: %0d, mismatches: %0d", completions, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
